// ===== hdl/sbil_pkg.sv =====
// ----------------------------------------------------------------------------
// sbil_pkg: shared types and constants for the strided box index locator.
// Holds field widths, the item record that moves down the cell chain and the
// stable axis ordering by stride magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbil_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int BASE_W      = 48;
	localparam int STRIDE_W    = 41;
	localparam int INDEX_W     = 50;
	localparam int AXES        = 3;
	localparam int AXIS_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int BIT_W       = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;
	localparam int PROD_W      = COUNT_BITS + STRIDE_W;
	localparam int REM_W       = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 3;
	localparam int SUM_W       = REM_W + 1;
	localparam int CELLS       = AXES * COUNT_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE     = 3'd0,
		REG_COUNT_X  = 3'd1,
		REG_COUNT_Y  = 3'd2,
		REG_COUNT_Z  = 3'd3,
		REG_STRIDE_X = 3'd4,
		REG_STRIDE_Y = 3'd5,
		REG_STRIDE_Z = 3'd6
	} cfg_reg_t;

	typedef logic [STRIDE_W-1:0]   mag_t;
	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [AXIS_W-1:0]     axis_t;

	typedef struct packed {
		logic                      fail;
		logic [REM_W-1:0]          rem;
		cnt_t                      quo;
		logic [AXES-1:0][COUNT_BITS-1:0] norm;
	} item_t;

	// Axes in order of falling magnitude, ties kept in axis order.
	function automatic logic [AXES-1:0][AXIS_W-1:0] axis_order(
		input logic [AXES-1:0][STRIDE_W-1:0] mag
	);
		axis_t o0;
		axis_t o1;
		axis_t o2;
		axis_t t;
		logic [AXES-1:0][AXIS_W-1:0] res;
		o0 = 2'd0;
		o1 = 2'd1;
		o2 = 2'd2;
		if (mag[o1] > mag[o0]) begin
			t = o0; o0 = o1; o1 = t;
		end
		if (mag[o2] > mag[o1]) begin
			t = o1; o1 = o2; o2 = t;
		end
		if (mag[o1] > mag[o0]) begin
			t = o0; o0 = o1; o1 = t;
		end
		res[0] = o0;
		res[1] = o1;
		res[2] = o2;
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sbil_cell.sv =====
// ----------------------------------------------------------------------------
// sbil_cell: one restoring-division cell of the locator chain.
// Resolves one quotient bit of one axis and hands the item to its neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbil_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_vld,
	input  wire sbil_pkg::item_t         in_item,
	input  wire sbil_pkg::mag_t          mag,
	input  wire sbil_pkg::cnt_t          cnt,
	input  wire sbil_pkg::axis_t         axis,
	input  wire logic [sbil_pkg::BIT_W-1:0] bit_pos,
	output logic                         out_vld_q,
	output sbil_pkg::item_t              out_item_q
);
	import sbil_pkg::*;

	item_t            nxt;
	logic [REM_W-1:0] div;
	logic [REM_W-1:0] lim;
	logic             nz;

	always_comb begin
		nz  = (mag != '0);
		div = REM_W'(mag) << bit_pos;
		lim = REM_W'(mag) << COUNT_BITS;
		nxt = in_item;
		if (bit_pos == BIT_W'(COUNT_BITS - 1)) begin
			nxt.quo = '0;
			if (nz && (in_item.rem >= lim)) begin
				nxt.fail = 1'b1;
			end
		end
		if (nz && (nxt.rem >= div)) begin
			nxt.rem          = nxt.rem - div;
			nxt.quo[bit_pos] = 1'b1;
		end
		if (bit_pos == '0) begin
			if ((nxt.quo >= cnt) || (!nz && (cnt != cnt_t'(1)))) begin
				nxt.fail = 1'b1;
			end
			nxt.norm[axis] = nxt.quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/strided_box_index_locate_core.sv =====
// ----------------------------------------------------------------------------
// strided_box_index_locate_core: locates a flat index in a 3-D strided box.
// Returns whether the index is a box element and its three coordinates.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the result side does not stall
// and returns one result per item, in order: s1 and s2 form the offset from
// the box's lowest address, one cell per quotient bit per axis divides by the
// stride magnitudes, and the output stage mirrors the coordinates into the
// output register. A stall on the result side holds the whole chain. The user
// must write configuration through its own port only while no item is in
// flight; the block does not enforce it. Writes apply from the next item.
`timescale 1ns / 1ps
`default_nettype none

module strided_box_index_locate_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sbil_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sbil_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire logic [sbil_pkg::INDEX_W-1:0]    flat_index,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output logic                                 inside_res,
	output logic [sbil_pkg::COUNT_BITS-1:0]      coord_x,
	output logic [sbil_pkg::COUNT_BITS-1:0]      coord_y,
	output logic [sbil_pkg::COUNT_BITS-1:0]      coord_z
);
	import sbil_pkg::*;

	logic [BASE_W-1:0]                 base_q;
	logic [AXES-1:0][COUNT_BITS-1:0]   count_q;
	logic [AXES-1:0][STRIDE_W-1:0]     stride_q;
	logic [AXES-1:0][STRIDE_W-1:0]     mag;
	logic [AXES-1:0]                   neg;
	logic [AXES-1:0][AXIS_W-1:0]       order;
	logic                              en;
	logic                              cnt_zero;

	logic                              vld_s1;
	logic [INDEX_W-1:0]                idx_s1;
	logic [AXES-1:0][PROD_W-1:0]       prod_s1;
	logic                              vld_s2;
	item_t                             item_s2;
	logic signed [SUM_W-1:0]           sum;

	logic [CELLS:0]                    vld_c;
	item_t                             item_c [CELLS+1];

	logic                              res_vld_q;
	logic                              inside_q;
	logic [AXES-1:0][COUNT_BITS-1:0]   coord_q;
	logic [AXES-1:0][COUNT_BITS-1:0]   coord_d;
	logic                              inside_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			count_q  <= {AXES{cnt_t'(1)}};
			stride_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE:     base_q      <= cfg_data[BASE_W-1:0];
				REG_COUNT_X:  count_q[0]  <= cfg_data[COUNT_BITS-1:0];
				REG_COUNT_Y:  count_q[1]  <= cfg_data[COUNT_BITS-1:0];
				REG_COUNT_Z:  count_q[2]  <= cfg_data[COUNT_BITS-1:0];
				REG_STRIDE_X: stride_q[0] <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_Y: stride_q[1] <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_Z: stride_q[2] <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			neg[a] = stride_q[a][STRIDE_W-1];
			mag[a] = neg[a] ? (~stride_q[a] + mag_t'(1)) : stride_q[a];
		end
		order    = axis_order(mag);
		cnt_zero = (count_q[0] == '0) || (count_q[1] == '0) || (count_q[2] == '0);
	end

	assign en         = !res_vld_q || !res_stall;
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= flat_index;
			for (int a = 0; a < AXES; a++) begin
				prod_s1[a] <= neg[a] ?
					(PROD_W'(count_q[a] - cnt_t'(1)) * PROD_W'(mag[a])) : '0;
			end
		end
	end

	always_comb begin
		sum = SUM_W'(signed'(idx_s1)) - signed'(SUM_W'(base_q))
			+ signed'(SUM_W'(prod_s1[0])) + signed'(SUM_W'(prod_s1[1]))
			+ signed'(SUM_W'(prod_s1[2]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.fail <= cnt_zero || sum[SUM_W-1];
			item_s2.rem  <= sum[REM_W-1:0];
			item_s2.quo  <= '0;
			item_s2.norm <= '0;
		end
	end

	assign vld_c[0]  = vld_s2;
	assign item_c[0] = item_s2;

	for (genvar k = 0; k < AXES; k++) begin : g_axis
		for (genvar j = 0; j < COUNT_BITS; j++) begin : g_bit
			sbil_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (en),
				.in_vld     (vld_c[k*COUNT_BITS + j]),
				.in_item    (item_c[k*COUNT_BITS + j]),
				.mag        (mag[order[k]]),
				.cnt        (count_q[order[k]]),
				.axis       (order[k]),
				.bit_pos    (BIT_W'(COUNT_BITS - 1 - j)),
				.out_vld_q  (vld_c[k*COUNT_BITS + j + 1]),
				.out_item_q (item_c[k*COUNT_BITS + j + 1])
			);
		end
	end

	always_comb begin
		inside_d = !item_c[CELLS].fail && (item_c[CELLS].rem == '0);
		for (int a = 0; a < AXES; a++) begin
			if (!inside_d) begin
				coord_d[a] = '0;
			end else if (neg[a]) begin
				coord_d[a] = count_q[a] - cnt_t'(1) - item_c[CELLS].norm[a];
			end else begin
				coord_d[a] = item_c[CELLS].norm[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= vld_c[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_q <= inside_d;
			coord_q  <= coord_d;
		end
	end

	assign res_valid  = res_vld_q;
	assign inside_res = inside_q;
	assign coord_x    = coord_q[0];
	assign coord_y    = coord_q[1];
	assign coord_z    = coord_q[2];

`ifndef SYNTHESIS
	a_inside_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && inside_res) |->
			(coord_x < count_q[0]) && (coord_y < count_q[1]) && (coord_z < count_q[2]))
		else $error("located coordinate outside the box");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !inside_res) |->
			(coord_x == '0) && (coord_y == '0) && (coord_z == '0))
		else $error("coordinates not cleared for an item outside the box");

	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && cnt_zero) |-> !inside_res)
		else $error("item found inside an empty box");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the strided box index locator.
// Writes a series of box shapes, drives flat indices through the item port
// under random bursts and result stalls, and checks every result in order
// against a behavioral model of the box lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import sbil_pkg::*;

	typedef struct packed {
		logic        ins;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] cz;
	} loc_t;

	typedef struct {
		logic [49:0] idx;
		logic        chk;
		loc_t        want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [INDEX_W-1:0] flat_index = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic inside_res;
	logic [15:0] coord_x, coord_y, coord_z;

	longint box_base;
	longint box_cnt[3];
	longint box_str[3];
	loc_t pending_locs[$];
	int errors = 0;
	int n_items = 0;
	int n_inside = 0;
	int hold_cycles = 0;
	int n_sets = 0;

	strided_box_index_locate_core u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic loc_t locate_index(longint idx);
		loc_t r;
		longint low, rem, reb;
		longint mag[3];
		longint nrm[3];
		longint crd[3];
		int ord[3];
		int t, a;
		r = '{1'b0, 16'd0, 16'd0, 16'd0};
		low = box_base;
		ord = '{0, 1, 2};
		for (a = 0; a < 3; a++) begin
			if (box_cnt[a] == 0) return r;
			mag[a] = box_str[a] < 0 ? -box_str[a] : box_str[a];
			if (box_str[a] < 0) low += (box_cnt[a] - 1) * box_str[a];
		end
		rem = idx - low;
		for (int i = 1; i < 3; i++)
			for (int j = i; j > 0 && mag[ord[j]] > mag[ord[j-1]]; j--) begin
				t = ord[j]; ord[j] = ord[j-1]; ord[j-1] = t;
			end
		for (int i = 0; i < 3; i++) begin
			a = ord[i];
			if (mag[a] == 0) begin
				if (box_cnt[a] != 1) return r;
				nrm[a] = 0;
				continue;
			end
			if (rem < 0) return r;
			nrm[a] = rem / mag[a];
			if (nrm[a] >= box_cnt[a]) return r;
			rem = rem % mag[a];
		end
		if (rem != 0) return r;
		reb = box_base;
		for (a = 0; a < 3; a++) begin
			crd[a] = box_str[a] < 0 ? box_cnt[a] - 1 - nrm[a] : nrm[a];
			reb += crd[a] * box_str[a];
		end
		if (reb != idx) return r;
		r = '{1'b1, crd[0][15:0], crd[1][15:0], crd[2][15:0]};
		return r;
	endfunction

	task automatic write_reg(cfg_reg_t r, logic [47:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (r)
			REG_BASE: box_base = longint'(v);
			REG_COUNT_X: box_cnt[0] = v[15:0];
			REG_COUNT_Y: box_cnt[1] = v[15:0];
			REG_COUNT_Z: box_cnt[2] = v[15:0];
			REG_STRIDE_X: box_str[0] = longint'(signed'(v[40:0]));
			REG_STRIDE_Y: box_str[1] = longint'(signed'(v[40:0]));
			default: box_str[2] = longint'(signed'(v[40:0]));
		endcase
	endtask

	task automatic set_box(logic [47:0] b, logic [15:0] c0, c1, c2,
			logic [40:0] s0, s1, s2);
		write_reg(REG_BASE, b);
		write_reg(REG_COUNT_X, c0);
		write_reg(REG_COUNT_Y, c1);
		write_reg(REG_COUNT_Z, c2);
		write_reg(REG_STRIDE_X, {{7{s0[40]}}, s0});
		write_reg(REG_STRIDE_Y, {{7{s1[40]}}, s1});
		write_reg(REG_STRIDE_Z, {{7{s2[40]}}, s2});
		n_sets++;
	endtask

	task automatic send_item(logic [49:0] v, logic chk, loc_t want);
		loc_t p;
		p = locate_index(longint'(signed'(v)));
		if (chk && p != want) begin
			$error("table row %0h: model disagrees with typed result", v);
			errors++;
		end
		item_valid <= 1'b1;
		flat_index <= v;
		do @(posedge clk); while (item_stall);
		pending_locs = {pending_locs, p};
		n_items++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_locs.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Index near an element of the current box, mostly exact, at times random.
	function automatic logic [49:0] pick_index();
		longint v;
		v = box_base;
		for (int a = 0; a < 3; a++)
			if (box_cnt[a] > 0)
				v += longint'($urandom_range(0, box_cnt[a] - 1)) * box_str[a];
		case ($urandom_range(0, 9))
			0: return 50'({$urandom, $urandom});
			1: v += longint'($urandom_range(0, 6)) - 3;
			default: ;
		endcase
		return v[49:0];
	endfunction

	function automatic logic [40:0] pick_stride(int lvl);
		logic [40:0] s;
		case ($urandom_range(0, 5))
			0: s = 41'd0;
			1: s = 41'({$urandom, $urandom});
			default: s = 41'($urandom_range(1, 8)) << (lvl * 8);
		endcase
		if ($urandom_range(0, 1)) s = -s;
		return s;
	endfunction

	row_t rows[] = '{
		'{50'd0, 1'b1, '{1'b1, 16'd0, 16'd0, 16'd0}},
		'{50'd1, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0}},
		'{50'h1FFFFFFFFFFFF, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0}},
		'{50'h2000000000000, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0}},
		'{50'h3FFFFFFFFFFFF, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0}}
	};

	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if (pending_locs.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				loc_t e;
				e = pending_locs.pop_front();
				if (inside_res !== e.ins) begin
					$error("inside_res exp %0d got %0d", e.ins, inside_res); errors++;
				end
				if (coord_x !== e.cx) begin
					$error("coord_x exp %0d got %0d", e.cx, coord_x); errors++;
				end
				if (coord_y !== e.cy) begin
					$error("coord_y exp %0d got %0d", e.cy, coord_y); errors++;
				end
				if (coord_z !== e.cz) begin
					$error("coord_z exp %0d got %0d", e.cz, coord_z); errors++;
				end
				if (e.ins) n_inside++;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			res_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			res_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 7) > 2);
		end
	end

	initial begin
		box_base = 0;
		box_cnt = '{1, 1, 1};
		box_str = '{0, 0, 0};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_item(rows[i].idx, rows[i].chk, rows[i].want);
		drain();
		set_box(48'hFFFFFFFFFFFF, 16'hFFFF, 16'd1, 16'd0, 41'h0FFFFFFFFFF, 41'd0,
			41'h10000000000);
		send_item(50'h0FFFFFFFFFFFF, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0});
		drain();
		set_box(48'd1000, 16'd4, 16'd3, 16'd2, 41'd1, -41'sd4, 41'd12);
		for (int i = 0; i < 20; i++) send_item(50'd985 + i, 1'b0, '{default: '0});
		send_item(50'd1000, 1'b1, '{1'b1, 16'd0, 16'd0, 16'd0});
		drain();
		set_box(48'd500, 16'd5, 16'd1, 16'd3, 41'd0, 41'd0, 41'd7);
		for (int i = 0; i < 6; i++) send_item(50'd493 + 7 * i, 1'b0, '{default: '0});
		drain();
		for (int ph = 0; ph < 14; ph++) begin
			set_box(48'({$urandom, $urandom}),
				$urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 9)),
				16'($urandom_range(1, 9)), 16'($urandom_range(0, 9)),
				pick_stride(0), pick_stride(1), pick_stride(2));
			if (ph == 3) hold_cycles <= 300;
			for (int k = 0; k < 125;) begin
				int burst;
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && k < 125; b++, k++)
					send_item(pick_index(), 1'b0, '{default: '0});
				if ($urandom_range(0, 2) == 0) begin
					item_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
			drain();
		end
		$display("Covered %0d items over %0d box settings, %0d found inside.",
			n_items, n_sets, n_inside);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== strided_box_index_locate_core.f =====
hdl/sbil_pkg.sv
hdl/sbil_cell.sv
hdl/strided_box_index_locate_core.sv
sim/tb_top.sv
